[design/i2a_pkg.sv]
// Package for the integer to ASCII formatter.
// Holds the beat payload types, format codes, controller states, command and
// status structs and the digit character function. Depends on nothing.
`default_nettype none

package i2a_pkg;

   // Format selector codes carried in the request beat.
   typedef enum logic [2:0] {
      FMT_SIGNED_DEC   = 3'd0,
      FMT_UNSIGNED_DEC = 3'd1,
      FMT_HEX_LOWER    = 3'd2,
      FMT_HEX_UPPER    = 3'd3,
      FMT_POINTER      = 3'd4
   } fmt_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [63:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
      logic [4:0] char_count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_STRIP,
      ST_PREFIX,
      ST_DIGITS
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic dd_step;
      logic strip_step;
      logic emit_prefix;
      logic emit_digit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic start_dec;
      logic start_hex;
      logic dd_last;
      logic top_zero;
      logic ndig_one;
      logic pre_any;
      logic pre_one;
      logic out_free;
   } status_type;

   localparam int NumBits      = 32;
   localparam int NumBcdDigits = 10;
   localparam int NumHexDigits = 16;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (nib < 4'd10) begin
         digit_char = CHAR_ZERO + {4'b0000, nib};
      end else begin
         digit_char = base + {4'b0000, nib} - 8'd10;
      end
   endfunction

endpackage

`default_nettype wire

[design/i2a_ctrl.sv]
// Controller state machine of the integer to ASCII formatter.
// Sequences load, binary to BCD conversion, leading zero strip and emission.
// Depends on i2a_pkg.
`default_nettype none

module i2a_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire i2a_pkg::status_type status,
   output i2a_pkg::cmd_type        cmd
);
   import i2a_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.start_dec) begin
                  state_in = ST_CONV;
               end else if (status.start_hex) begin
                  state_in = ST_STRIP;
               end
            end
         end
         ST_CONV: begin
            cmd.dd_step = 1'b1;
            if (status.dd_last) begin
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (status.top_zero && !status.ndig_one) begin
               cmd.strip_step = 1'b1;
            end else if (status.pre_any) begin
               state_in = ST_PREFIX;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_PREFIX: begin
            if (status.out_free) begin
               cmd.emit_prefix = 1'b1;
               if (status.pre_one) begin
                  state_in = ST_DIGITS;
               end
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.ndig_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/i2a_datapath.sv]
// Datapath of the integer to ASCII formatter.
// Double-dabble BCD converter, digit shift register and output register.
// Depends on i2a_pkg.
`default_nettype none

module i2a_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire i2a_pkg::req_payload_type req_data,
   input  wire i2a_pkg::cmd_type        cmd,
   output i2a_pkg::status_type          status,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output i2a_pkg::rsp_payload_type     rsp_data
);
   import i2a_pkg::*;

   logic [2:0]              mode_ff;
   logic [NumBits-1:0]      mag_ff;
   logic [4*NumBcdDigits-1:0] bcd_ff;
   logic [4*NumBcdDigits-1:0] bcd_adj;
   logic [4*NumBcdDigits-1:0] bcd_in;
   logic [4:0]              bit_cnt_ff;
   logic [4*NumHexDigits-1:0] dig_ff;
   logic [4:0]              ndig_ff;
   logic [1:0]              pre_ff;
   logic [4:0]              cnt_ff;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_ff;
   rsp_payload_type         rsp_in;
   logic [31:0]             low;
   logic                    negative;
   logic                    emit;

   assign low      = req_data.value[31:0];
   assign negative = (req_data.action == FMT_SIGNED_DEC) && low[31];
   assign emit     = cmd.emit_prefix || cmd.emit_digit;

   // One double-dabble step: adjust every BCD digit, then shift in one bit.
   always_comb begin
      for (int i = 0; i < NumBcdDigits; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
      bcd_in = {bcd_adj[4*NumBcdDigits-2:0], mag_ff[NumBits-1]};
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.emit_prefix) begin
         if (mode_ff == FMT_POINTER) begin
            rsp_in.char_code = (pre_ff == 2'd2) ? CHAR_ZERO : CHAR_X;
         end else begin
            rsp_in.char_code = CHAR_MINUS;
         end
      end else begin
         rsp_in.char_code = digit_char(dig_ff[4*NumHexDigits-1 -: 4],
                                       mode_ff == FMT_HEX_UPPER);
         rsp_in.last       = ndig_ff == 5'd1;
         rsp_in.char_count = (ndig_ff == 5'd1) ? cnt_ff + 5'd1 : 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_data.action;
         mag_ff     <= negative ? (~low + 32'd1) : low;
         bcd_ff     <= '0;
         bit_cnt_ff <= '0;
         dig_ff     <= req_data.value;
         ndig_ff    <= 5'(NumHexDigits);
         cnt_ff     <= '0;
         if (req_data.action == FMT_POINTER) begin
            pre_ff <= 2'd2;
         end else if (negative) begin
            pre_ff <= 2'd1;
         end else begin
            pre_ff <= 2'd0;
         end
      end
      if (cmd.dd_step) begin
         bcd_ff     <= bcd_in;
         mag_ff     <= {mag_ff[NumBits-2:0], 1'b0};
         bit_cnt_ff <= bit_cnt_ff + 5'd1;
         if (status.dd_last) begin
            dig_ff  <= {bcd_in, {(4*(NumHexDigits-NumBcdDigits)){1'b0}}};
            ndig_ff <= 5'(NumBcdDigits);
         end
      end
      if (cmd.strip_step || cmd.emit_digit) begin
         dig_ff  <= {dig_ff[4*NumHexDigits-5:0], 4'b0000};
         ndig_ff <= ndig_ff - 5'd1;
      end
      if (cmd.emit_prefix) begin
         pre_ff <= pre_ff - 2'd1;
      end
      if (emit) begin
         cnt_ff <= cnt_ff + 5'd1;
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status           = '0;
      status.start_dec = (req_data.action == FMT_SIGNED_DEC) ||
                         (req_data.action == FMT_UNSIGNED_DEC);
      status.start_hex = (req_data.action == FMT_HEX_LOWER) ||
                         (req_data.action == FMT_HEX_UPPER) ||
                         (req_data.action == FMT_POINTER);
      status.dd_last   = bit_cnt_ff == 5'(NumBits - 1);
      status.top_zero  = dig_ff[4*NumHexDigits-1 -: 4] == 4'b0000;
      status.ndig_one  = ndig_ff == 5'd1;
      status.pre_any   = pre_ff != 2'd0;
      status.pre_one   = pre_ff == 2'd1;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A character is only written into the output register when it is free.
   assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("character written over an untaken beat");

   // The final digit of a number always shows up flagged as last.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && status.ndig_one) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("final digit not flagged as last");

   // Only the last beat of a number carries a nonzero count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> (rsp_ff.char_count == 5'd0))
      else $error("count on a beat that is not last");

   // Prefix characters are never emitted once the prefix is used up.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_prefix |-> (pre_ff != 2'd0))
      else $error("prefix emitted past its length");

endmodule

`default_nettype wire

[design/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter.
// Joins the controller (i2a_ctrl) and the datapath (i2a_datapath); uses i2a_pkg.
`default_nettype none

// Channel   Direction  Payload            Meaning
// req_      in         req_payload_type   format selector and 64-bit number
// rsp_      out        rsp_payload_type   one ASCII character per beat, last flag, count
//
// A request beat is taken only in idle. Decimal formats first run a double-dabble
// conversion; every format then drops leading zeros, decides on a prefix and emits
// one character per beat. Selector codes 5 to 7 produce no beats; reset is synchronous.
// A low rsp_ready holds the current character and pauses emission.

module integer_to_ascii_formatter (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire i2a_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output i2a_pkg::rsp_payload_type      rsp_data
);
   import i2a_pkg::*;

   // Command and status between the two halves.
   cmd_type    cmd;
   status_type status;

   // The controller owns the request handshake and sequences the datapath.
   i2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the number, its digits and the output register.
   i2a_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
